### rtl/gdfw_pkg.sv
// Package for the depth-first graph walk: sizes, codes, state encoding and
// the request structs between the sequencer and its memories. No dependencies.
`timescale 1ns / 1ps

package gdfw_pkg;

  localparam int NODES      = 16;
  localparam int EDGE_SLOTS = 32;

  localparam int NODE_W  = 4;
  localparam int LEVEL_W = 5;
  localparam int SLVL_W  = 4;
  localparam int EDGE_AW = $clog2(EDGE_SLOTS);
  localparam int COUNT_W = $clog2(EDGE_SLOTS + 1);
  localparam int TOP_W   = $clog2(NODES);

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [TOP_W-1:0]   top_t;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    EV_ENTER = 3'd0,
    EV_SKIP  = 3'd1,
    EV_RET   = 3'd2,
    EV_ADDED = 3'd3,
    EV_FULL  = 3'd4
  } ev_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDRES,
    S_START,
    S_SCAN,
    S_HIT,
    S_RET,
    S_POP
  } state_t;

  typedef struct packed {
    logic               wr;
    logic [EDGE_AW-1:0] addr;
    node_t              origin;
    node_t              target;
  } edge_req_t;

  typedef struct packed {
    logic   wr;
    top_t   addr;
    node_t  node;
    count_t pos;
  } frame_req_t;

endpackage

### rtl/gdfw_if.sv
// Request channel interfaces of the depth-first graph walk.
// Depends on gdfw_pkg for the field types.
`timescale 1ns / 1ps

interface gdfw_in_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           command;
  gdfw_pkg::node_t      source_node;
  gdfw_pkg::node_t      dest_node;
  logic [gdfw_pkg::SLVL_W-1:0] start_level;

  modport source (output valid, command, source_node, dest_node, start_level,
                  input ready);
  modport sink (input valid, command, source_node, dest_node, start_level,
                output ready);
endinterface

interface gdfw_out_if;
  logic             valid;
  logic             ready;
  logic [2:0]       event_res;
  gdfw_pkg::node_t  node;
  gdfw_pkg::level_t level;
  logic             last;

  modport source (output valid, event_res, node, level, last, input ready);
  modport sink (input valid, event_res, node, level, last, output ready);
endinterface

### rtl/gdfw_edge_mem.sv
// Edge store of the graph walk: one synchronous memory of origin/target pairs
// with a single port and registered read data. Depends on gdfw_pkg.
`timescale 1ns / 1ps

module gdfw_edge_mem (
  input  logic                clk,
  input  gdfw_pkg::edge_req_t req,
  output gdfw_pkg::node_t     rd_origin,
  output gdfw_pkg::node_t     rd_target
);
  import gdfw_pkg::*;

  logic [2*NODE_W-1:0] mem [EDGE_SLOTS];

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= {req.origin, req.target};
    end
    {rd_origin, rd_target} <= mem[req.addr];
  end

endmodule

### rtl/gdfw_frame_mem.sv
// Frame stack of the graph walk: node and scan position of each suspended
// frame, one synchronous single-port memory. Depends on gdfw_pkg.
`timescale 1ns / 1ps

module gdfw_frame_mem (
  input  logic                 clk,
  input  gdfw_pkg::frame_req_t req,
  output gdfw_pkg::node_t      rd_node,
  output gdfw_pkg::count_t     rd_pos
);
  import gdfw_pkg::*;

  logic [NODE_W+COUNT_W-1:0] mem [NODES];

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= {req.node, req.pos};
    end
    {rd_node, rd_pos} <= mem[req.addr];
  end

endmodule

### rtl/graph_depth_first_walk.sv
// Depth-first walk over a directed graph held in an edge memory; one request at a time.
// Add: one result, from S_ADDRES through the output register. Clear: no result.
// Run: one edge read per cycle in S_SCAN; the walk waits in S_START, S_HIT and S_RET while
// the output stalls. Found edges go through S_HIT, returns through S_RET, pops through S_POP.
// Reset (synchronous, rst_n low) empties the edge store, clears the visited marks and the
// output valid; the memories themselves are not cleared.
`timescale 1ns / 1ps

module graph_depth_first_walk (
  input logic       clk,
  input logic       rst_n,
  gdfw_in_if.sink   in_chan,
  gdfw_out_if.source out_chan
);
  import gdfw_pkg::*;

  state_t     state_r, state_nxt;
  count_t     edge_count_r, edge_count_nxt;
  logic [NODES-1:0] visited_r, visited_nxt;
  node_t      cur_r, cur_nxt;
  count_t     scan_pos_r, scan_pos_nxt;
  count_t     pend_pos_r, pend_pos_nxt;
  logic       pend_r, pend_nxt;
  top_t       top_r, top_nxt;
  logic [SLVL_W-1:0] lvl0_r, lvl0_nxt;
  node_t      hit_node_r, hit_node_nxt;
  ev_t        res_ev_r, res_ev_nxt;
  node_t      res_node_r, res_node_nxt;

  logic       out_valid_r, out_valid_nxt;
  ev_t        out_ev_r;
  node_t      out_node_r;
  level_t     out_level_r;
  logic       out_last_r;

  logic       emit;
  ev_t        emit_ev;
  node_t      emit_node;
  level_t     emit_level;
  logic       emit_last;
  logic       can_emit;
  logic       accept;
  level_t     cur_level;

  edge_req_t  edge_req;
  frame_req_t frame_req;
  node_t      edge_rd_origin, edge_rd_target;
  node_t      frame_rd_node;
  count_t     frame_rd_pos;

  gdfw_edge_mem u_edge_mem (
    .clk       (clk),
    .req       (edge_req),
    .rd_origin (edge_rd_origin),
    .rd_target (edge_rd_target)
  );

  gdfw_frame_mem u_frame_mem (
    .clk     (clk),
    .req     (frame_req),
    .rd_node (frame_rd_node),
    .rd_pos  (frame_rd_pos)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign can_emit      = !out_valid_r || out_chan.ready;
  assign cur_level     = {1'b0, lvl0_r} + {{(LEVEL_W-TOP_W){1'b0}}, top_r};

  always_comb begin
    state_nxt      = state_r;
    edge_count_nxt = edge_count_r;
    visited_nxt    = visited_r;
    cur_nxt        = cur_r;
    scan_pos_nxt   = scan_pos_r;
    pend_pos_nxt   = pend_pos_r;
    pend_nxt       = pend_r;
    top_nxt        = top_r;
    lvl0_nxt       = lvl0_r;
    hit_node_nxt   = hit_node_r;
    res_ev_nxt     = res_ev_r;
    res_node_nxt   = res_node_r;
    emit           = 1'b0;
    emit_ev        = EV_ENTER;
    emit_node      = cur_r;
    emit_level     = cur_level;
    emit_last      = 1'b0;
    edge_req       = '{wr: 1'b0, addr: scan_pos_r[EDGE_AW-1:0],
                       origin: in_chan.source_node, target: in_chan.dest_node};
    frame_req      = '{wr: 1'b0, addr: top_r, node: cur_r, pos: scan_pos_r};

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          priority if (in_chan.command == CMD_ADD) begin
            res_node_nxt = in_chan.source_node;
            if (edge_count_r >= COUNT_W'(EDGE_SLOTS)) begin
              res_ev_nxt = EV_FULL;
            end else begin
              res_ev_nxt     = EV_ADDED;
              edge_req.wr    = 1'b1;
              edge_req.addr  = edge_count_r[EDGE_AW-1:0];
              edge_count_nxt = edge_count_r + 1'b1;
            end
            state_nxt = S_ADDRES;
          end else if (in_chan.command == CMD_RUN) begin
            visited_nxt[in_chan.source_node] = 1'b1;
            cur_nxt      = in_chan.source_node;
            scan_pos_nxt = '0;
            pend_nxt     = 1'b0;
            top_nxt      = '0;
            lvl0_nxt     = in_chan.start_level;
            state_nxt    = S_START;
          end else if (in_chan.command == CMD_CLEAR) begin
            edge_count_nxt = '0;
            visited_nxt    = '0;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_ADDRES: begin
        if (can_emit) begin
          emit       = 1'b1;
          emit_ev    = res_ev_r;
          emit_node  = res_node_r;
          emit_level = '0;
          emit_last  = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_START: begin
        if (can_emit) begin
          emit      = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (pend_r && (edge_rd_origin == cur_r)) begin
          hit_node_nxt = edge_rd_target;
          scan_pos_nxt = pend_pos_r + 1'b1;
          pend_nxt     = 1'b0;
          state_nxt    = S_HIT;
        end else if (scan_pos_r >= edge_count_r) begin
          pend_nxt  = 1'b0;
          state_nxt = S_RET;
        end else begin
          pend_nxt     = 1'b1;
          pend_pos_nxt = scan_pos_r;
          scan_pos_nxt = scan_pos_r + 1'b1;
        end
      end
      S_HIT: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_node = hit_node_r;
          if (!visited_r[hit_node_r] && (top_r < TOP_W'(NODES - 1))) begin
            frame_req.wr            = 1'b1;
            visited_nxt[hit_node_r] = 1'b1;
            cur_nxt                 = hit_node_r;
            scan_pos_nxt            = '0;
            top_nxt                 = top_r + 1'b1;
            emit_ev                 = EV_ENTER;
            emit_level              = cur_level + 1'b1;
          end else begin
            emit_ev = EV_SKIP;
          end
          state_nxt = S_SCAN;
        end
      end
      S_RET: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_ev   = EV_RET;
          emit_last = (top_r == '0);
          if (top_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            frame_req.addr = top_r - 1'b1;
            top_nxt        = top_r - 1'b1;
            state_nxt      = S_POP;
          end
        end
      end
      S_POP: begin
        cur_nxt      = frame_rd_node;
        scan_pos_nxt = frame_rd_pos;
        pend_nxt     = 1'b0;
        state_nxt    = S_SCAN;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = emit || (out_valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      edge_count_r <= '0;
      visited_r    <= '0;
      pend_r       <= 1'b0;
      top_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      edge_count_r <= edge_count_nxt;
      visited_r    <= visited_nxt;
      pend_r       <= pend_nxt;
      top_r        <= top_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    scan_pos_r <= scan_pos_nxt;
    pend_pos_r <= pend_pos_nxt;
    lvl0_r     <= lvl0_nxt;
    hit_node_r <= hit_node_nxt;
    res_ev_r   <= res_ev_nxt;
    res_node_r <= res_node_nxt;
    if (emit) begin
      out_ev_r    <= emit_ev;
      out_node_r  <= emit_node;
      out_level_r <= emit_level;
      out_last_r  <= emit_last;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.event_res = out_ev_r;
  assign out_chan.node      = out_node_r;
  assign out_chan.level     = out_level_r;
  assign out_chan.last      = out_last_r;

endmodule

### rtl/gdfw_checker.sv
// Port-level checker for the depth-first graph walk, bound to the top level.
// Depends on gdfw_pkg for the command codes.
`timescale 1ns / 1ps

module gdfw_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_command,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_event_res,
  input logic [3:0] out_node,
  input logic [4:0] out_level,
  input logic       out_last
);
  import gdfw_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_res)
      && $stable(out_node) && $stable(out_level) && $stable(out_last))
    else $error("result changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !out_valid |=> !out_valid)
    else $error("result appeared in the cycle after a request");

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_command == CMD_ADD || in_command == CMD_RUN) |=> !in_ready)
    else $error("new request taken while one is in progress");

endmodule

bind graph_depth_first_walk gdfw_checker u_gdfw_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .in_command    (in_chan.command),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_event_res (out_chan.event_res),
  .out_node      (out_chan.node),
  .out_level     (out_chan.level),
  .out_last      (out_chan.last)
);
